// ===== sv/mler_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mler_pkg
// Shared operation and status codes for the multi-listener event router.
// ----------------------------------------------------------------------------
package mler_pkg;

  typedef enum logic [2:0] {
    FN_REGISTER   = 3'd0,
    FN_UNREGISTER = 3'd1,
    FN_UNREG_ALL  = 3'd2,
    FN_TRIGGER    = 3'd3,
    FN_DISPATCH   = 3'd4,
    FN_COUNT      = 3'd5,
    FN_RSVD6      = 3'd6,
    FN_RSVD7      = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_ZERO_HNDL = 3'd2,
    ST_LIST_FULL = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_Q_FULL    = 3'd6,
    ST_Q_EMPTY   = 3'd7
  } status_t;

endpackage : mler_pkg
`default_nettype wire

// ===== sv/multi_listener_event_router.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_listener_event_router
// Per-event listener lists in block memory plus a ring queue of pending events.
// ----------------------------------------------------------------------------
// One item at a time: the next item is taken once the last result of the
// previous one has been accepted at the output. Register and unregister walk
// the event's listener list one entry per cycle through the synchronous table
// memory (one read port); on a match, unregister then moves the last entry
// into the slot it frees. Dispatch pops the queue memory and then streams one
// result per listener, each once its listener read returns from the table;
// output stalls hold the stream. A result register sits on the output. At
// most QUEUE_DEPTH-1 events wait in the queue.
module multi_listener_event_router #(
  parameter int NUM_EVENTS          = 16,
  parameter int LISTENERS_PER_EVENT = 8,
  parameter int QUEUE_DEPTH         = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [2:0]            func,
  input  wire  [7:0]            event_num,
  input  wire  [31:0]           handler,
  input  wire  [31:0]           argument,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [2:0]            status,
  output logic                  call_valid,
  output logic [31:0]           call_handler,
  output logic [31:0]           call_argument,
  output logic [3:0]            dispatched_event,
  output logic                  last,
  output logic [3:0]            listener_count,
  output logic [31:0]           overrun_count,
  output logic [4:0]            queue_level
);
  import mler_pkg::*;

  localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int LW = (LISTENERS_PER_EVENT > 1) ? $clog2(LISTENERS_PER_EVENT) : 1;
  localparam int CW = $clog2(LISTENERS_PER_EVENT + 1);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int TD = NUM_EVENTS * LISTENERS_PER_EVENT;
  localparam int TW = (TD > 1) ? $clog2(TD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_SWAP_RD, S_SWAP_WR, S_QRD, S_DSP_RD, S_DSP_OUT,
    S_RESP
  } state_t;

  state_t state;

  // memories
  logic [63:0]   tbl [TD];
  logic [EW-1:0] pq  [QUEUE_DEPTH];
  logic [CW-1:0] cnt [NUM_EVENTS];

  logic [63:0]   tbl_rd;
  logic [TW-1:0] tbl_ra;
  logic          tbl_we;
  logic [TW-1:0] tbl_wa;
  logic [63:0]   tbl_wd;
  logic [EW-1:0] pq_rd;

  logic [QW-1:0] head, tail;
  logic [31:0]   overruns;

  // item
  func_t         op;
  logic [EW-1:0] ev;
  logic          good;
  logic [31:0]   h, a;
  logic [CW-1:0] n;
  logic [CW-1:0] idx;
  logic [LW-1:0] hit;
  status_t       st;

  logic [QW-1:0] tail_inc, head_inc;
  logic [QW-1:0] lvl;
  logic [TW-1:0] base;
  logic          out_free;
  logic          out_load;

  assign tail_inc = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign lvl      = (tail >= head) ? QW'(tail - head) : QW'(QUEUE_DEPTH + tail - head);
  assign base     = TW'(ev) * TW'(LISTENERS_PER_EVENT);

  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state == S_RESP ||
                                 (state == S_DSP_OUT && (n == '0 || good)));

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_wa] <= tbl_wd;
    tbl_rd <= tbl[tbl_ra];
    pq_rd  <= pq[head];
    if (state == S_CHECK && op == FN_TRIGGER && good && tail_inc != head)
      pq[tail] <= ev;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    tbl_ra = base + TW'(idx);
    tbl_we = 1'b0;
    tbl_wa = base + TW'(idx);
    tbl_wd = {h, a};
    if (state == S_CHECK && op == FN_REGISTER && good && h != '0 && cnt[ev] == '0)
      tbl_we = 1'b1;
    if (state == S_SCAN && op == FN_REGISTER && idx == n && n != '0)
      tbl_we = 1'b1;
    if (state == S_SWAP_RD) tbl_ra = base + TW'(n - 1'b1);
    if (state == S_SWAP_WR) begin
      tbl_we = 1'b1;
      tbl_wa = base + TW'(hit);
      tbl_wd = tbl_rd;
    end
  end

  task automatic emit(input status_t s, input logic cv, input logic [63:0] ha,
                      input logic [3:0] de, input logic ls, input logic [3:0] lc);
    status           <= s;
    call_valid       <= cv;
    {call_handler, call_argument} <= ha;
    dispatched_event <= de;
    last             <= ls;
    listener_count   <= lc;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      overruns  <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) cnt[i] <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op    <= func_t'(func);
            good  <= {1'b0, event_num} < 9'(NUM_EVENTS);
            ev    <= EW'(event_num);
            h     <= handler;
            a     <= argument;
            idx   <= '0;
            st    <= ST_OK;
            state <= (func_t'(func) == FN_DISPATCH) ? S_QRD : S_CHECK;
          end
        end
        S_CHECK: begin
          n <= cnt[ev];
          state <= S_RESP;
          if (!good) begin
            st <= (op == FN_RSVD6 || op == FN_RSVD7) ? ST_OK : ST_BAD_ID;
          end else begin
            unique case (op)
              FN_REGISTER: begin
                if (h == '0) st <= ST_ZERO_HNDL;
                else if (cnt[ev] >= CW'(LISTENERS_PER_EVENT)) st <= ST_LIST_FULL;
                else if (cnt[ev] == '0) cnt[ev] <= CW'(1);
                else state <= S_SCAN;
              end
              FN_UNREGISTER: begin
                if (h == '0) st <= ST_ZERO_HNDL;
                else if (cnt[ev] == '0) st <= ST_NOT_FOUND;
                else state <= S_SCAN;
              end
              FN_UNREG_ALL: cnt[ev] <= '0;
              FN_TRIGGER: begin
                if (tail_inc == head) begin
                  overruns <= overruns + 1'b1;
                  st <= ST_Q_FULL;
                end else tail <= tail_inc;
              end
              default: ;
            endcase
          end
          idx <= CW'(1);
        end
        // read address idx issued; tbl_rd holds entry idx-1
        S_SCAN: begin
          if (tbl_rd == {h, a}) begin
            hit <= LW'(idx - 1'b1);
            if (op == FN_REGISTER) begin
              st <= ST_DUPLICATE;
              state <= S_RESP;
            end else state <= S_SWAP_RD;
          end else if (idx == n) begin
            if (op == FN_REGISTER) cnt[ev] <= n + 1'b1;
            else st <= ST_NOT_FOUND;
            state <= S_RESP;
          end else idx <= idx + 1'b1;
        end
        S_SWAP_RD: state <= S_SWAP_WR;
        S_SWAP_WR: begin
          cnt[ev] <= n - 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            emit(st, 1'b0, '0, 4'd0, 1'b1,
                 good ? 4'(cnt[ev]) : 4'd0);
            state <= S_IDLE;
          end
        end
        S_QRD: begin
          if (head == tail) begin
            st <= ST_Q_EMPTY;
            good <= 1'b0;
            state <= S_RESP;
          end else begin
            head <= head_inc;
            state <= S_DSP_RD;
          end
        end
        S_DSP_RD: begin
          ev  <= pq_rd;
          n   <= cnt[pq_rd];
          idx <= '0;
          good <= 1'b0;
          state <= S_DSP_OUT;
        end
        // good marks tbl_rd as holding entry idx; cleared on each idx change, set once the read returns
        S_DSP_OUT: begin
          if (n == '0) begin
            if (out_free) begin
              emit(ST_OK, 1'b0, '0, 4'(ev), 1'b1, 4'd0);
              state <= S_IDLE;
            end
          end else if (out_free && good) begin
            emit(ST_OK, 1'b1, tbl_rd, 4'(ev), idx == n - 1'b1, 4'(n));
            if (idx == n - 1'b1) state <= S_IDLE;
            else begin
              idx  <= idx + 1'b1;
              good <= 1'b0;
            end
          end else good <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign overrun_count = overruns;
  assign queue_level   = 5'(lvl);

endmodule : multi_listener_event_router
`default_nettype wire

// ===== sv/mler_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mler_checker
// Port-level checks for the event router.
// ----------------------------------------------------------------------------
module mler_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       call_valid,
  input wire [2:0] status,
  input wire       last
);
  import mler_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("item taken with result pending");

  a_call_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && call_valid |-> status == ST_OK)
    else $error("call with error status");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result not last");

endmodule : mler_checker

bind multi_listener_event_router mler_checker u_mler_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .call_valid(call_valid),
  .status(status), .last(last)
);
`default_nettype wire
